FILE: rtl/v3n_pkg.sv
// Shared constants for the vector normalise block: register map and port widths.
package v3n_pkg;

  localparam int MIN_LENGTH_BITS = 24;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_ADDR_BITS   = 3;
  localparam int MIN_SQ_BITS     = 2 * MIN_LENGTH_BITS;

  // Register indexes, selected by paddr[2]
  localparam logic REG_MIN_LENGTH = 1'b0;

  localparam logic [MIN_LENGTH_BITS-1:0] MIN_LENGTH_RESET = MIN_LENGTH_BITS'(1);

endpackage

FILE: rtl/vector3_normalize.sv
// Vector normalise top level: magnitude, square, sum, root and divide pipeline.
//
//  channel   signals                                       handshake
//  --------  --------------------------------------------  -------------------------
//  command   start, busy, comp_x, comp_y, comp_z           beat when start && !busy
//  result    done, unit_x, unit_y, unit_z, degenerate      beat when done (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata, prdata  APB, pready tied high
//
//  One beat enters every cycle; busy is never raised.
//  The square root yields one result bit per stage and the three divide
//  lanes one quotient bit per stage.
//  Reset clears the valid bits and sets min_length to 1.
//  The receiver cannot stall; every result is presented for one cycle only.
module vector3_normalize #(
  parameter int COMPONENT_BITS     = 24,
  parameter int UNIT_FRACTION_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COMPONENT_BITS-1:0]      comp_x,
  input  logic signed [COMPONENT_BITS-1:0]      comp_y,
  input  logic signed [COMPONENT_BITS-1:0]      comp_z,
  output logic                                  done,
  output logic signed [UNIT_FRACTION_BITS+1:0]  unit_x,
  output logic signed [UNIT_FRACTION_BITS+1:0]  unit_y,
  output logic signed [UNIT_FRACTION_BITS+1:0]  unit_z,
  output logic                                  degenerate,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [v3n_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [v3n_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [v3n_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                  pready
);
  import v3n_pkg::*;

  localparam int CB   = COMPONENT_BITS;
  localparam int UF   = UNIT_FRACTION_BITS;
  localparam int SB   = 2 * CB;
  localparam int QB   = UF + 1;
  localparam int UB   = UF + 2;
  localparam int CMPW = (SB > MIN_SQ_BITS) ? SB : MIN_SQ_BITS;
  localparam int RN   = CB + 1;
  localparam int DN   = UF + 1;

  // ---------------- configuration ----------------
  logic [MIN_LENGTH_BITS-1:0] min_length;
  logic [MIN_SQ_BITS-1:0]     min_sq;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
      min_sq     <= MIN_SQ_BITS'(1);
    end else if (cfg_wr) begin
      min_length <= pwdata[MIN_LENGTH_BITS-1:0];
      min_sq     <= pwdata[MIN_LENGTH_BITS-1:0] * pwdata[MIN_LENGTH_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_LENGTH) begin
      prdata = CFG_DATA_BITS'(min_length);
    end
  end

  // ---------------- stage 0: magnitudes ----------------
  logic                 s0_vld;
  logic [2:0][CB-1:0]   s0_mag;
  logic [2:0]           s0_neg;

  // ---------------- stage 1: squares ----------------
  logic                 s1_vld;
  logic [2:0][SB-1:0]   s1_sqr;
  logic [2:0][CB-1:0]   s1_mag;
  logic [2:0]           s1_neg;

  // ---------------- stage 2: sum ----------------
  logic                 s2_vld;
  logic [SB-1:0]        s2_sum;
  logic [2:0][CB-1:0]   s2_mag;
  logic [2:0]           s2_neg;

  // ---------------- root pipeline, entry 0 also holds the threshold test ----------
  logic                 r_vld   [RN];
  logic [CB+1:0]        r_rem   [RN];
  logic [CB-1:0]        r_root  [RN];
  logic [SB-1:0]        r_rest  [RN];
  logic [2:0][CB-1:0]   r_mag   [RN];
  logic [2:0]           r_neg   [RN];
  logic                 r_degen [RN];
  logic [CB+1:0]        r_rem_next  [RN];
  logic [CB-1:0]        r_root_next [RN];

  // ---------------- divide pipeline, three lanes ----------------
  logic                 d_vld   [DN];
  logic [2:0][CB:0]     d_rem   [DN];
  logic [2:0][QB-1:0]   d_q     [DN];
  logic [CB-1:0]        d_len   [DN];
  logic [2:0]           d_neg   [DN];
  logic                 d_degen [DN];
  logic [2:0][CB:0]     d_rem_next [DN];
  logic [2:0][QB-1:0]   d_q_next   [DN];

  logic [2:0][CB-1:0]   in_comp;
  assign in_comp = {comp_z, comp_y, comp_x};

  // root step: bring down two bits, trial subtract (root<<2)|1
  always_comb begin
    logic [CB+1:0] sh;
    logic [CB+1:0] trial;
    for (int j = 0; j < RN - 1; j++) begin
      sh    = {r_rem[j][CB-1:0], r_rest[j][SB-1 -: 2]};
      trial = {r_root[j], 2'b01};
      if (sh >= trial) begin
        r_rem_next[j]  = sh - trial;
        r_root_next[j] = {r_root[j][CB-2:0], 1'b1};
      end else begin
        r_rem_next[j]  = sh;
        r_root_next[j] = {r_root[j][CB-2:0], 1'b0};
      end
    end
    r_rem_next[RN-1]  = r_rem[RN-1];
    r_root_next[RN-1] = r_root[RN-1];
  end

  // divide step: first entry tests the integer bit, later entries one fraction bit each
  always_comb begin
    logic [CB:0] sh;
    for (int l = 0; l < 3; l++) begin
      if ({1'b0, r_mag[RN-1][l]} >= {1'b0, r_root[RN-1]}) begin
        d_rem_next[0][l] = {1'b0, r_mag[RN-1][l]} - {1'b0, r_root[RN-1]};
        d_q_next[0][l]   = QB'(1);
      end else begin
        d_rem_next[0][l] = {1'b0, r_mag[RN-1][l]};
        d_q_next[0][l]   = '0;
      end
      for (int j = 1; j < DN; j++) begin
        sh = {d_rem[j-1][l][CB-1:0], 1'b0};
        if (sh >= {1'b0, d_len[j-1]}) begin
          d_rem_next[j][l] = sh - {1'b0, d_len[j-1]};
          d_q_next[j][l]   = {d_q[j-1][l][QB-2:0], 1'b1};
        end else begin
          d_rem_next[j][l] = sh;
          d_q_next[j][l]   = {d_q[j-1][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      for (int j = 0; j < RN; j++) r_vld[j] <= 1'b0;
      for (int j = 0; j < DN; j++) d_vld[j] <= 1'b0;
      done <= 1'b0;
    end else begin
      s0_vld   <= start;
      s1_vld   <= s0_vld;
      s2_vld   <= s1_vld;
      r_vld[0] <= s2_vld;
      for (int j = 1; j < RN; j++) r_vld[j] <= r_vld[j-1];
      d_vld[0] <= r_vld[RN-1];
      for (int j = 1; j < DN; j++) d_vld[j] <= d_vld[j-1];
      done <= d_vld[DN-1];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      s0_neg[l] <= in_comp[l][CB-1];
      s0_mag[l] <= in_comp[l][CB-1] ? (~in_comp[l] + CB'(1)) : in_comp[l];
      s1_sqr[l] <= SB'(s0_mag[l]) * SB'(s0_mag[l]);
    end
    s1_mag <= s0_mag;
    s1_neg <= s0_neg;

    s2_sum <= s1_sqr[0] + s1_sqr[1] + s1_sqr[2];
    s2_mag <= s1_mag;
    s2_neg <= s1_neg;

    r_rem[0]   <= '0;
    r_root[0]  <= '0;
    r_rest[0]  <= s2_sum;
    r_mag[0]   <= s2_mag;
    r_neg[0]   <= s2_neg;
    r_degen[0] <= (CMPW'(s2_sum) < CMPW'(min_sq)) || (s2_sum == '0);
    for (int j = 1; j < RN; j++) begin
      r_rem[j]   <= r_rem_next[j-1];
      r_root[j]  <= r_root_next[j-1];
      r_rest[j]  <= {r_rest[j-1][SB-3:0], 2'b00};
      r_mag[j]   <= r_mag[j-1];
      r_neg[j]   <= r_neg[j-1];
      r_degen[j] <= r_degen[j-1];
    end

    d_rem[0]   <= d_rem_next[0];
    d_q[0]     <= d_q_next[0];
    d_len[0]   <= r_root[RN-1];
    d_neg[0]   <= r_neg[RN-1];
    d_degen[0] <= r_degen[RN-1];
    for (int j = 1; j < DN; j++) begin
      d_rem[j]   <= d_rem_next[j];
      d_q[j]     <= d_q_next[j];
      d_len[j]   <= d_len[j-1];
      d_neg[j]   <= d_neg[j-1];
      d_degen[j] <= d_degen[j-1];
    end

    // apply sign, zero the vector when degenerate
    degenerate <= d_degen[DN-1];
    if (d_degen[DN-1]) begin
      unit_x <= '0;
      unit_y <= '0;
      unit_z <= '0;
    end else begin
      unit_x <= d_neg[DN-1][0] ? -$signed({1'b0, d_q[DN-1][0]}) : $signed({1'b0, d_q[DN-1][0]});
      unit_y <= d_neg[DN-1][1] ? -$signed({1'b0, d_q[DN-1][1]}) : $signed({1'b0, d_q[DN-1][1]});
      unit_z <= d_neg[DN-1][2] ? -$signed({1'b0, d_q[DN-1][2]}) : $signed({1'b0, d_q[DN-1][2]});
    end
  end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the vector normalise block, with a predictor and directed plus random beats.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import v3n_pkg::*;

  localparam int CB = 24;
  localparam int UB = 16;
  localparam int UFB = 14;
  localparam int LATENCY = CB + UFB + 6;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_MIN_LENGTH = {REG_MIN_LENGTH, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_UNUSED = {~REG_MIN_LENGTH, 2'b00};
  localparam logic signed [CB-1:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [CB-1:0] CMIN = -24'sh800000;
  localparam logic signed [UB-1:0] UONE = 16'sd16384;

  typedef struct packed {
    logic signed [UB-1:0] ux;
    logic signed [UB-1:0] uy;
    logic signed [UB-1:0] uz;
    logic deg;
  } unit_vec_t;

  typedef struct {
    logic signed [CB-1:0] x, y, z;
    bit typed;
    unit_vec_t want;
  } vec_row_t;

  logic clk = 0, rst = 1, start = 0;
  logic signed [CB-1:0] comp_x = '0, comp_y = '0, comp_z = '0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic busy, done, degenerate, pready;
  logic signed [UB-1:0] unit_x, unit_y, unit_z;
  logic [CFG_DATA_BITS-1:0] prdata;

  logic [MIN_LENGTH_BITS-1:0] threshold;
  unit_vec_t pending_units[$];
  int errors = 0, checked = 0, flagged = 0;
  bit idling = 1;

  vector3_normalize dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [UB-1:0] unit_of(longint c, longint unsigned len);
    longint unsigned m = (c < 0) ? -c : c;
    longint unsigned q = (m << UFB) / len;
    if (c < 0) q = -q;
    return q[UB-1:0];
  endfunction

  function automatic unit_vec_t normalise(logic signed [CB-1:0] x, y, z);
    longint sx = x, sy = y, sz = z;
    longint unsigned sumsq = sx*sx + sy*sy + sz*sz;
    longint unsigned t = threshold;
    longint unsigned len;
    unit_vec_t r;
    if (sumsq < t*t || sumsq == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, deg: 1'b1};
      return r;
    end
    len = isqrt(sumsq);
    r.ux = unit_of(sx, len);
    r.uy = unit_of(sy, len);
    r.uz = unit_of(sz, len);
    r.deg = 1'b0;
    return r;
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    unit_vec_t w;
    if (!rst && done) begin
      if (pending_units.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %0d %0d %0d deg %0b",
                 $time, unit_x, unit_y, unit_z, degenerate);
      end else begin
        w = pending_units.pop_front();
        checked++;
        if (w.deg) flagged++;
        if (unit_x !== w.ux || unit_y !== w.uy || unit_z !== w.uz || degenerate !== w.deg) begin
          errors++;
          $display("%0t: mismatch expected %0d %0d %0d deg %0b, actual %0d %0d %0d deg %0b",
                   $time, w.ux, w.uy, w.uz, w.deg, unit_x, unit_y, unit_z, degenerate);
        end
      end
    end
  end

  task automatic send(vec_row_t row);
    if (idling && $urandom_range(0, 5) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    start = 1;
    comp_x = row.x;
    comp_y = row.y;
    comp_z = row.z;
    do @(posedge clk); while (busy);
    pending_units.push_back(row.typed ? row.want : normalise(row.x, row.y, row.z));
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain();
    start = 0;
    while (pending_units.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic apb_write(logic [CFG_ADDR_BITS-1:0] a, logic [CFG_DATA_BITS-1:0] d);
    psel = 1; pwrite = 1; penable = 0; paddr = a; pwdata = d;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    if (a == ADDR_MIN_LENGTH) threshold = d[MIN_LENGTH_BITS-1:0];
    // read back the register
    psel = 1; paddr = ADDR_MIN_LENGTH;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    if (prdata[MIN_LENGTH_BITS-1:0] !== threshold) begin
      errors++;
      $display("%0t: min_length read expected %0d, actual %0d", $time, threshold, prdata);
    end
    @(negedge clk);
    psel = 0; penable = 0;
  endtask

  function automatic logic signed [CB-1:0] pick_comp();
    int unsigned t = threshold;
    case ($urandom_range(0, 4))
      0, 1: return CB'($urandom);
      2: return CB'($signed(CB'($urandom_range(0, 600))) - 300);
      3: case ($urandom_range(0, 4))
           0: return CMAX;
           1: return CMIN;
           2: return CB'(0);
           3: return CB'(1);
           default: return CB'(-1);
         endcase
      default: return CB'((t + $urandom_range(0, 4) - 2) * ($urandom_range(0, 1) ? 1 : -1));
    endcase
  endfunction

  task automatic random_phase(int n);
    vec_row_t row;
    row.typed = 0;
    repeat (n) begin
      row.x = pick_comp();
      row.y = ($urandom_range(0, 2) == 0) ? CB'(0) : pick_comp();
      row.z = pick_comp();
      send(row);
    end
  endtask

  vec_row_t directed[] = '{
    '{0, 0, 0, 1, '{0, 0, 0, 1}},
    '{CMAX, 0, 0, 1, '{UONE, 0, 0, 0}},
    '{CMIN, 0, 0, 1, '{-UONE, 0, 0, 0}},
    '{0, 1, 0, 1, '{0, UONE, 0, 0}},
    '{0, 0, -1, 1, '{0, 0, -UONE, 0}},
    '{0, CMIN, 0, 1, '{0, -UONE, 0, 0}},
    '{0, 0, CMAX, 1, '{0, 0, UONE, 0}},
    '{1, 1, 1, 1, '{UONE, UONE, UONE, 0}},
    '{3, 4, 0, 1, '{16'sd9830, 16'sd13107, 0, 0}},
    '{CMAX, CMAX, CMAX, 0, '{0, 0, 0, 0}},
    '{CMIN, CMIN, CMIN, 0, '{0, 0, 0, 0}},
    '{CMIN, CMAX, CMIN, 0, '{0, 0, 0, 0}},
    '{-24'sd1, 24'sd2, -24'sd2, 0, '{0, 0, 0, 0}},
    '{24'sd4096, -24'sd4096, 24'sd1, 0, '{0, 0, 0, 0}},
    '{24'sh555555, -24'sh2AAAAA, 24'sh0F0F0F, 0, '{0, 0, 0, 0}}
  };

  initial begin
    vec_row_t row;
    threshold = MIN_LENGTH_RESET;
    repeat (12) @(negedge clk);
    rst = 0;
    foreach (directed[i]) send(directed[i]);
    random_phase(200);
    drain();

    // zero threshold: the zero vector must still be flagged
    apb_write(ADDR_MIN_LENGTH, 32'd0);
    row = '{0, 0, 0, 1, '{0, 0, 0, 1}};
    send(row);
    random_phase(180);
    drain();

    // upper data bits are dropped, giving the largest threshold
    apb_write(ADDR_MIN_LENGTH, 32'hFFFF_FFFF);
    random_phase(150);
    drain();

    // index out of range is ignored
    apb_write(ADDR_UNUSED, 32'd77);
    random_phase(100);
    drain();

    apb_write(ADDR_MIN_LENGTH, 32'd5000);
    random_phase(200);
    drain();

    apb_write(ADDR_MIN_LENGTH, 32'h0080_0000);
    random_phase(150);
    drain();

    apb_write(ADDR_MIN_LENGTH, 32'd37);
    random_phase(100);
    idling = 0;
    random_phase(120);
    drain();

    $display("Checked %0d result beats (%0d degenerate) over six min_length values,",
             checked, flagged);
    $display("including extremes, the zero vector and an ignored register address.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
